// ===== sv/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg: shared types, constants and helpers for differential drive odometry
// Holds the angle constants, the arctangent table, the sequencer states and
// the saturation and wrap helpers used by the odometry datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

   // Arctangent table depth and its index width
   localparam int ATAN_ENTRIES = 30;
   localparam int ATAN_IDX_W   = 5;

   // Divider operand widths
   localparam int DIV_NUM_W = 69;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_Q_W   = 70;

   typedef logic signed [33:0] angle_type;

   // Angles in Q3.28, CORDIC start gain in Q2.30
   localparam angle_type PI_Q28      = 34'sd843314857;
   localparam angle_type TWO_PI_Q28  = 34'sd1686629714;
   localparam angle_type HALF_PI_Q28 = 34'sd421657428;
   localparam angle_type CORDIC_GAIN = 34'sd652032874;

   // Register indexes
   localparam logic [1:0] REG_METRES_PER_TICK    = 2'd0;
   localparam logic [1:0] REG_INV_TRACK_WIDTH    = 2'd1;
   localparam logic [1:0] REG_STRAIGHT_THRESHOLD = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_MDL, S_MDR, S_SUM, S_MAG, S_MHI, S_MLO, S_DTH, S_ANG,
      S_C0S, S_C0W, S_C1S, S_C1W, S_DIFF, S_MX, S_MY, S_YS,
      S_AMS, S_AMC, S_DVX, S_DVY, S_OUT
   } state_type;

   // floor(atan(2^-i) * 2^30) for i up to 28; zero beyond
   function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
      logic [29:0] r;
      case (i)
         5'd0:  r = 30'd843314856;
         5'd1:  r = 30'd497837829;
         5'd2:  r = 30'd263043836;
         5'd3:  r = 30'd133525158;
         5'd4:  r = 30'd67021686;
         5'd5:  r = 30'd33543515;
         5'd6:  r = 30'd16775850;
         5'd7:  r = 30'd8388437;
         5'd8:  r = 30'd4194282;
         5'd9:  r = 30'd2097149;
         5'd10: r = 30'd1048575;
         5'd11: r = 30'd524287;
         5'd12: r = 30'd262143;
         5'd13: r = 30'd131071;
         5'd14: r = 30'd65535;
         5'd15: r = 30'd32767;
         5'd16: r = 30'd16383;
         5'd17: r = 30'd8191;
         5'd18: r = 30'd4095;
         5'd19: r = 30'd2047;
         5'd20: r = 30'd1023;
         5'd21: r = 30'd511;
         5'd22: r = 30'd255;
         5'd23: r = 30'd127;
         5'd24: r = 30'd63;
         5'd25: r = 30'd31;
         5'd26: r = 30'd15;
         5'd27: r = 30'd7;
         5'd28: r = 30'd3;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

   // Wrap into [-pi, pi]; inputs stay within two turns of the range
   function automatic angle_type wrap_angle(input angle_type a);
      angle_type r;
      r = a;
      if (r > PI_Q28) r = r - TWO_PI_Q28;
      if (r > PI_Q28) r = r - TWO_PI_Q28;
      if (r < -PI_Q28) r = r + TWO_PI_Q28;
      if (r < -PI_Q28) r = r + TWO_PI_Q28;
      return r;
   endfunction

   // Saturate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [31:0] r;
      if (v > 72'sd2147483647) r = 32'sh7fffffff;
      else if (v < -72'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic: iterative rotation-mode CORDIC
// Wraps and folds the angle, then runs one micro-rotation a cycle and
// returns cosine and sine in Q2.30 with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_cordic #(
   parameter int STEPS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire ddo_pkg::angle_type angle,
   output logic                    done,
   output ddo_pkg::angle_type      cos_out,
   output ddo_pkg::angle_type      sin_out
);
   import ddo_pkg::*;

   localparam int NITER = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;
   localparam int IW    = $clog2(NITER);

   angle_type       x_ff, y_ff, z_ff;
   angle_type       a_wrap, a_fold;
   angle_type       xs, ys, atan_v;
   logic            fold;
   logic            flip_ff;
   logic [IW-1:0]   i_ff;
   logic            busy_ff, done_ff;

   // Wrap and fold the argument into [-pi/2, pi/2]
   always_comb begin
      a_wrap = wrap_angle(angle);
      a_fold = a_wrap;
      fold   = 1'b0;
      if (a_wrap > HALF_PI_Q28) begin
         a_fold = a_wrap - PI_Q28;
         fold   = 1'b1;
      end else if (a_wrap < -HALF_PI_Q28) begin
         a_fold = a_wrap + PI_Q28;
         fold   = 1'b1;
      end
   end

   assign xs     = x_ff >>> i_ff;
   assign ys     = y_ff >>> i_ff;
   assign atan_v = {4'b0, atan_q30(ATAN_IDX_W'(i_ff))};

   // Sequence the micro-rotations
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            i_ff    <= '0;
            flip_ff <= fold;
            x_ff    <= CORDIC_GAIN;
            y_ff    <= '0;
            z_ff    <= a_fold <<< 2;
         end else if (busy_ff) begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_v;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_v;
            end
            if (i_ff == IW'(NITER - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            i_ff <= i_ff + 1'b1;
         end
      end
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

`default_nettype wire

// ===== sv/ddo_div.sv =====
// ----------------------------------------------------------------------------
// ddo_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit a cycle, quotient
// truncated toward zero and signed at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [ddo_pkg::DIV_NUM_W-1:0] num,
   input  wire logic signed [ddo_pkg::DIV_DEN_W-1:0] den,
   output logic                                      done,
   output logic signed [ddo_pkg::DIV_Q_W-1:0]        quo
);
   import ddo_pkg::*;

   localparam int CW = $clog2(DIV_NUM_W);

   logic [DIV_NUM_W-1:0] qn_ff;
   logic [DIV_DEN_W-1:0] rem_ff, dm_ff;
   logic [DIV_DEN_W:0]   r2;
   logic                 ge;
   logic                 neg_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff, done_ff;

   // Trial subtract
   assign r2 = {rem_ff, qn_ff[DIV_NUM_W-1]};
   assign ge = r2 >= {1'b0, dm_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            qn_ff   <= num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
            dm_ff   <= den[DIV_DEN_W-1] ? DIV_DEN_W'(-den) : DIV_DEN_W'(den);
            neg_ff  <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
         end else if (busy_ff) begin
            rem_ff <= ge ? DIV_DEN_W'(r2 - {1'b0, dm_ff}) : DIV_DEN_W'(r2);
            qn_ff  <= {qn_ff[DIV_NUM_W-2:0], ge};
            if (cnt_ff == CW'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed({1'b0, qn_ff}) : $signed({1'b0, qn_ff});

endmodule

`default_nettype wire

// ===== sv/differential_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry: fixed-point pose update from wheel ticks
// Turns tick deltas into a linear and heading step and advances the pose
// by a chord or an exact arc, using a shared multiplier, CORDIC and divider.
// ----------------------------------------------------------------------------
//  channel  direction  width  contents
//  req      in         48     ticks_left, ticks_right
//  rsp      out        160    pose_x_out, pose_y_out, heading_out, linear_step,
//                             heading_step, straight_used
//  csr      in         2+32   register index, write data
//
//  A chord request runs one CORDIC pass of N = min(CORDIC_STEPS, 30)
//  iterations; an arc request runs two such passes and then two 69-step
//  divisions.
//  One request is in work at a time; req_tready is high only when idle.
//  A finished result waits in the output register while the next request
//  is taken; the pose is committed when the result is loaded.
//  Reset is synchronous and clears the pose and the registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry #(
   parameter int CORDIC_STEPS = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // ticks_left [23:0], ticks_right [47:24]
   input  wire logic [47:0]  req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pose_x_out [31:0], pose_y_out [63:32], heading_out [94:64],
   // linear_step [126:95], heading_step [158:127], straight_used [159]
   output logic [159:0]      rsp_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   import ddo_pkg::*;

   state_type state_ff, state_in;

   // Configuration
   logic [31:0] mpt_ff, itw_ff;
   logic [28:0] thr_ff;

   // Pose
   logic signed [31:0] pose_x_ff, pose_y_ff, heading_ff;

   // Working registers
   logic signed [23:0] tl_ff, tr_ff;
   logic signed [56:0] dl_ff;
   logic signed [57:0] sum_ff, diff_ff;
   logic [56:0]        mag_ff;
   logic               neg_ff;
   logic signed [31:0] lin_ff, dth_ff;
   logic [61:0]        phi_ff, p_sum;
   logic               straight_ff;
   angle_type          nh_ff, mid_ff;
   angle_type          c0_ff, s0_ff, c1_ff, s1_ff;
   logic signed [34:0] ds_ff, dc_ff;
   logic signed [31:0] nx_ff, ny_ff;
   logic signed [32:0] absd;

   // Shared multiplier
   logic               mul_en;
   logic signed [32:0] mul_a;
   logic signed [35:0] mul_b;
   logic signed [68:0] mul_p_ff;

   // CORDIC and divider
   logic      cor_start, cor_done;
   angle_type cor_angle, cor_cos, cor_sin;
   logic      div_start, div_done;
   logic signed [DIV_Q_W-1:0] div_q;

   logic rsp_tvalid_ff;
   logic [159:0] rsp_tdata_ff;
   logic out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   ddo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mul_p_ff),
      .den   (dth_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   // Next state, multiplier operands and unit starts
   always_comb begin
      state_in  = state_ff;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      cor_start = 1'b0;
      cor_angle = straight_ff ? mid_ff : 34'(heading_ff);
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_MDL;
         S_MDL: begin
            mul_en = 1'b1; mul_a = 33'(tl_ff); mul_b = {4'b0, mpt_ff};
            state_in = S_MDR;
         end
         S_MDR: begin
            mul_en = 1'b1; mul_a = 33'(tr_ff); mul_b = {4'b0, mpt_ff};
            state_in = S_SUM;
         end
         S_SUM: state_in = S_MAG;
         S_MAG: state_in = S_MHI;
         S_MHI: begin
            mul_en = 1'b1; mul_a = {8'b0, mag_ff[56:32]}; mul_b = {4'b0, itw_ff};
            state_in = S_MLO;
         end
         S_MLO: begin
            mul_en = 1'b1; mul_a = {1'b0, mag_ff[31:0]}; mul_b = {4'b0, itw_ff};
            state_in = S_DTH;
         end
         S_DTH: state_in = S_ANG;
         S_ANG: state_in = S_C0S;
         S_C0S: begin
            cor_start = 1'b1;
            state_in  = S_C0W;
         end
         S_C0W: if (cor_done) state_in = straight_ff ? S_MX : S_C1S;
         S_C1S: begin
            cor_start = 1'b1;
            cor_angle = nh_ff;
            state_in  = S_C1W;
         end
         S_C1W: if (cor_done) state_in = S_DIFF;
         S_DIFF: state_in = S_AMS;
         S_MX: begin
            mul_en = 1'b1; mul_a = 33'(lin_ff); mul_b = 36'(c0_ff);
            state_in = S_MY;
         end
         S_MY: begin
            mul_en = 1'b1; mul_a = 33'(lin_ff); mul_b = 36'(s0_ff);
            state_in = S_YS;
         end
         S_YS: state_in = S_OUT;
         S_AMS: begin
            mul_en = 1'b1; mul_a = 33'(lin_ff); mul_b = 36'(ds_ff);
            state_in = S_AMC;
         end
         S_AMC: begin
            mul_en = 1'b1; mul_a = 33'(lin_ff); mul_b = 36'(dc_ff);
            div_start = 1'b1;
            state_in  = S_DVX;
         end
         S_DVX: if (div_done) begin
            div_start = 1'b1;
            state_in  = S_DVY;
         end
         S_DVY: if (div_done) state_in = S_OUT;
         S_OUT: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // Multiply, registered
   always_ff @(posedge clock) begin
      if (mul_en) mul_p_ff <= mul_a * mul_b;
   end

   assign p_sum = phi_ff + 62'(mul_p_ff[63:28]);
   assign absd  = dth_ff[31] ? -33'(dth_ff) : 33'(dth_ff);

   // Datapath steps
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: if (req_tvalid) begin
            tl_ff <= req_tdata[23:0];
            tr_ff <= req_tdata[47:24];
         end
         S_MDR: dl_ff <= mul_p_ff[56:0];
         S_SUM: begin
            sum_ff  <= 58'($signed(mul_p_ff[56:0])) + 58'(dl_ff);
            diff_ff <= 58'($signed(mul_p_ff[56:0])) - 58'(dl_ff);
         end
         S_MAG: begin
            mag_ff <= diff_ff[57] ? 57'(-diff_ff) : diff_ff[56:0];
            neg_ff <= diff_ff[57];
            lin_ff <= sat32(72'(sum_ff) >>> 17);
         end
         // Hold the upper partial product, scaled to the heading format
         S_MLO: phi_ff <= 62'({mul_p_ff[56:0], 4'b0});
         S_DTH: begin
            if (neg_ff) dth_ff <= (p_sum > 62'd2147483648) ? 32'sh80000000
                                                          : 32'(-p_sum);
            else        dth_ff <= (p_sum > 62'd2147483647) ? 32'sh7fffffff
                                                          : p_sum[31:0];
         end
         S_ANG: begin
            straight_ff <= (dth_ff == 0) || (absd < $signed({4'b0, thr_ff}));
            nh_ff       <= wrap_angle(34'(heading_ff) + 34'(dth_ff));
            mid_ff      <= 34'(heading_ff) + (34'(dth_ff) >>> 1);
         end
         S_C0W: if (cor_done) begin
            c0_ff <= cor_cos;
            s0_ff <= cor_sin;
         end
         S_C1W: if (cor_done) begin
            c1_ff <= cor_cos;
            s1_ff <= cor_sin;
         end
         S_DIFF: begin
            ds_ff <= 35'(s1_ff) - 35'(s0_ff);
            dc_ff <= 35'(c1_ff) - 35'(c0_ff);
         end
         S_MY: nx_ff <= sat32(72'(pose_x_ff) + (72'(mul_p_ff) >>> 30));
         S_YS: ny_ff <= sat32(72'(pose_y_ff) + (72'(mul_p_ff) >>> 30));
         S_DVX: if (div_done) nx_ff <= sat32(72'(pose_x_ff) + (72'(div_q) >>> 2));
         S_DVY: if (div_done) ny_ff <= sat32(72'(pose_y_ff) - (72'(div_q) >>> 2));
         default: ;
      endcase
   end

   // Configuration, pose commit and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mpt_ff        <= 32'd2635249;
         itw_ff        <= 32'd33554432;
         thr_ff        <= 29'd268;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         heading_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_METRES_PER_TICK:    mpt_ff <= csr_data;
               REG_INV_TRACK_WIDTH:    itw_ff <= csr_data;
               REG_STRAIGHT_THRESHOLD: thr_ff <= csr_data[28:0];
               default: ;
            endcase
         end
         if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_ff <= 1'b0;
         if (state_ff == S_OUT && out_free) begin
            pose_x_ff     <= nx_ff;
            pose_y_ff     <= ny_ff;
            heading_ff    <= nh_ff[31:0];
            rsp_tvalid_ff <= 1'b1;
            rsp_tdata_ff  <= {straight_ff, dth_ff, lin_ff, nh_ff[30:0], ny_ff, nx_ff};
         end
      end
   end

   // Heading stays wrapped
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      heading_ff <= 32'sd843314857 && heading_ff >= -32'sd843314857)
      else $error("heading left [-pi, pi]");

   // CORDIC finishes only while the sequencer waits for it
   a_cor_done: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == S_C0W || state_ff == S_C1W))
      else $error("unexpected CORDIC done");

   // Divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DVX || state_ff == S_DVY))
      else $error("unexpected divider done");

   // Zero heading change always takes the chord
   a_zero_straight: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tdata_ff[158:127] == 32'd0) |-> rsp_tdata_ff[159])
      else $error("zero heading step without chord");

endmodule

`default_nettype wire

// ===== sim/differential_drive_odometry_tb.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_tb: self-checking bench for the odometry block
// Drives tick deltas in random bursts, writes the three registers between
// phases, and checks each pose update against a bit-true predictor of the
// chord and arc updates.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ddo_pkg::*;

   localparam int  STEPS       = 24;
   localparam int  IDLE_LIMIT  = 20000;
   localparam int  NUM_DIRECT  = 16;
   localparam longint PI_VAL   = 843314857;
   localparam longint TWO_PI   = 1686629714;
   localparam longint HALF_PI  = 421657428;
   localparam longint START_X  = 652032874;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   // first member lands in the top bits of the result word
   typedef struct packed {
      logic               straight;
      logic signed [31:0] dth;
      logic signed [31:0] lin;
      logic signed [30:0] heading;
      logic signed [31:0] pose_y;
      logic signed [31:0] pose_x;
   } pose_update_t;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
      bit                 known;
      pose_update_t       value;
   } tick_row_t;

   // floor(atan(2^-i) * 2^30) for i up to 28; the last entry is zero
   localparam longint ARCTAN [30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149,
      1048575, 524287, 262143, 131071, 65535,
      32767, 16383, 8191, 4095, 2047,
      1023, 511, 255, 127, 63,
      31, 15, 7, 3, 0};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [47:0]  req_tdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   // predictor state and register copies
   longint            odo_x, odo_y, odo_h;
   longint unsigned   mpt, itw, thr;
   pose_update_t      pending_poses[$];
   int                mismatches = 0;
   int                idle_cycles = 0;
   int                burst_left = 0;
   int                cycle_count = 0;
   tick_row_t         direct_rows[NUM_DIRECT];

   differential_drive_odometry u_top (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint sat_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint wrap_pi(input longint a);
      longint r;
      r = a;
      while (r > PI_VAL) r -= TWO_PI;
      while (r < -PI_VAL) r += TWO_PI;
      return r;
   endfunction

   // rotation-mode CORDIC, angle Q3.28 in, cos and sin Q2.30 out
   task automatic rotate(input longint ang, output longint cv, output longint sv);
      longint a, x, y, z, nx;
      bit     flip;
      a = wrap_pi(ang);
      flip = 1'b0;
      x = START_X;
      y = 0;
      if (a > HALF_PI) begin
         a -= PI_VAL;
         flip = 1'b1;
      end else if (a < -HALF_PI) begin
         a += PI_VAL;
         flip = 1'b1;
      end
      z = a * 4;
      for (int i = 0; i < STEPS && i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= ARCTAN[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += ARCTAN[i];
         end
         x = nx;
      end
      cv = flip ? -x : x;
      sv = flip ? -y : y;
   endtask

   // advance the predicted pose by one request
   task automatic advance_pose(input logic signed [23:0] tl, input logic signed [23:0] tr,
                               output pose_update_t res);
      longint dl, dr, lin, diff, dth, absd, nx, ny, nh, c0, s0, c1, s1;
      longint unsigned mag, p;
      bit straight;
      dl = longint'(tl) * longint'(mpt);
      dr = longint'(tr) * longint'(mpt);
      lin = sat_word((dr + dl) >>> 17);
      diff = dr - dl;
      mag = diff < 0 ? longint'(-diff) : diff;
      p = (((mag >> 32) * itw) << 4) + (((mag & 64'hffffffff) * itw) >> 28);
      if (diff < 0)
         dth = p > 64'd2147483648 ? -64'sd2147483648 : -longint'(p);
      else
         dth = p > 64'd2147483647 ? 64'sd2147483647 : longint'(p);
      absd = dth < 0 ? -dth : dth;
      straight = (dth == 0) || (absd < longint'(thr));
      nh = wrap_pi(odo_h + dth);
      if (straight) begin
         rotate(odo_h + (dth >>> 1), c0, s0);
         nx = odo_x + ((lin * c0) >>> 30);
         ny = odo_y + ((lin * s0) >>> 30);
      end else begin
         rotate(odo_h, c0, s0);
         rotate(nh, c1, s1);
         nx = odo_x + (((lin * (s1 - s0)) / dth) >>> 2);
         ny = odo_y - (((lin * (c1 - c0)) / dth) >>> 2);
      end
      odo_x = sat_word(nx);
      odo_y = sat_word(ny);
      odo_h = nh;
      res.pose_x   = odo_x[31:0];
      res.pose_y   = odo_y[31:0];
      res.heading  = odo_h[30:0];
      res.lin      = lin[31:0];
      res.dth      = dth[31:0];
      res.straight = straight;
   endtask

   // send one request in bursts, predict on acceptance
   task automatic send_ticks(input logic signed [23:0] tl, input logic signed [23:0] tr,
                             input bit known, input pose_update_t typed);
      pose_update_t res;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_tdata  <= {tr, tl};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      advance_pose(tl, tr, res);
      pending_poses.push_back(known ? typed : res);
   endtask

   // hold until every pose has come back, then let the block settle
   task automatic drain_poses();
      req_tvalid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_METRES_PER_TICK:    mpt = 64'(val);
         REG_INV_TRACK_WIDTH:    itw = 64'(val);
         REG_STRAIGHT_THRESHOLD: thr = 64'(val[28:0]);
         default: ;
      endcase
   endtask

   task automatic random_ticks(output logic signed [23:0] tl, output logic signed [23:0] tr);
      int base;
      base = $urandom_range(0, 2000) - 1000;
      case ($urandom_range(0, 5))
         0: begin
            tl = 24'(base);
            tr = 24'(base);
         end
         1, 2: begin
            tl = 24'(base);
            tr = 24'(base + int'($urandom_range(0, 400)) - 200);
         end
         3: begin
            tl = 24'(int'($urandom_range(0, 40000)) - 20000);
            tr = 24'(int'($urandom_range(0, 40000)) - 20000);
         end
         4: begin
            tl = 24'($urandom);
            tr = 24'($urandom);
         end
         default: begin
            tl = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            tr = $urandom_range(0, 1) ? 24'sh7fffff : 24'($urandom);
         end
      endcase
   endtask

   // result side: stall on its own pattern, check in order
   always @(posedge clock) begin
      pose_update_t got, want;
      cycle_count <= cycle_count + 1;
      if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            want = pending_poses.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch x %0d/%0d y %0d/%0d h %0d/%0d lin %0d/%0d dth %0d/%0d st %0b/%0b",
                     want.pose_x, got.pose_x, want.pose_y, got.pose_y,
                     want.heading, got.heading, want.lin, got.lin,
                     want.dth, got.dth, want.straight, got.straight);
            end
         end
      end
      if ((cycle_count / 700) % 3 == 0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // watchdog: count cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("differential_drive_odometry test failed");
         $finish;
      end
   end

   initial begin
      logic signed [23:0] tl, tr;
      pose_update_t zero_pose;
      odo_x = 0;
      odo_y = 0;
      odo_h = 0;
      mpt = 2635249;
      itw = 33554432;
      thr = 268;
      zero_pose = '0;
      zero_pose.straight = 1'b1;

      // still at reset: both wheels idle gives the origin on the chord branch
      direct_rows = '{
         '{24'sd0, 24'sd0, 1'b1, zero_pose},
         '{24'sh7fffff, 24'sh7fffff, 1'b0, zero_pose},
         '{24'sh800000, 24'sh800000, 1'b0, zero_pose},
         '{24'sh800000, 24'sh7fffff, 1'b0, zero_pose},
         '{24'sh7fffff, 24'sh800000, 1'b0, zero_pose},
         '{24'sd100, -24'sd100, 1'b0, zero_pose},
         '{24'sd1, 24'sd0, 1'b0, zero_pose},
         '{24'sd0, 24'sd1, 1'b0, zero_pose},
         '{-24'sd1, -24'sd1, 1'b0, zero_pose},
         '{24'sd1000, 24'sd1200, 1'b0, zero_pose},
         '{24'sd5000, -24'sd3000, 1'b0, zero_pose},
         '{24'sd3000, 24'sd2999, 1'b0, zero_pose},
         '{24'sh555555, 24'shaaaaaa, 1'b0, zero_pose},
         '{24'shaaaaaa, 24'sh555555, 1'b0, zero_pose},
         '{-24'sd20000, 24'sd20000, 1'b0, zero_pose},
         '{24'sd7, 24'sd7, 1'b0, zero_pose}};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset settings
      foreach (direct_rows[i])
         send_ticks(direct_rows[i].left, direct_rows[i].right,
                    direct_rows[i].known, direct_rows[i].value);
      drain_poses();

      // extremes: largest scale, zero threshold, saturating positions
      write_reg(REG_METRES_PER_TICK, 32'hffffffff);
      write_reg(REG_INV_TRACK_WIDTH, 32'hffffffff);
      write_reg(REG_STRAIGHT_THRESHOLD, 32'h0);
      send_ticks(24'sd0, 24'sd0, 1'b0, zero_pose);
      send_ticks(24'sh7fffff, 24'sh7fffff, 1'b0, zero_pose);
      send_ticks(24'sh7fffff, 24'sh7fffff, 1'b0, zero_pose);
      send_ticks(24'sd1, 24'sd2, 1'b0, zero_pose);
      send_ticks(24'sh800000, 24'sh7fffff, 1'b0, zero_pose);
      drain_poses();

      // random phases, each with its own register settings
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin
               write_reg(REG_METRES_PER_TICK, 32'd2635249);
               write_reg(REG_INV_TRACK_WIDTH, 32'd33554432);
               write_reg(REG_STRAIGHT_THRESHOLD, 32'hffffffff);
            end
            1: begin
               write_reg(REG_METRES_PER_TICK, 32'h0);
               write_reg(REG_INV_TRACK_WIDTH, 32'h0);
               write_reg(REG_UNUSED, $urandom);
            end
            2: write_reg(REG_STRAIGHT_THRESHOLD, 32'd268435456);
            default: begin
               write_reg(REG_METRES_PER_TICK, $urandom_range(1 << 18, 1 << 24));
               write_reg(REG_INV_TRACK_WIDTH, $urandom_range(1 << 22, 1 << 27));
               write_reg(REG_STRAIGHT_THRESHOLD, $urandom_range(0, 1 << 24));
               if (ph == 6) write_reg(REG_METRES_PER_TICK, $urandom);
            end
         endcase
         for (int n = 0; n < 70; n++) begin
            random_ticks(tl, tr);
            send_ticks(tl, tr, 1'b0, zero_pose);
            if (n == 35 && ph == 3) drain_poses();
         end
         drain_poses();
      end

      repeat (300) @(posedge clock);
      if (mismatches == 0 && pending_poses.size() == 0)
         $display("differential_drive_odometry test passed");
      else
         $display("differential_drive_odometry test failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/ddo_pkg.sv
sv/ddo_cordic.sv
sv/ddo_div.sv
sv/differential_drive_odometry.sv
sim/differential_drive_odometry_tb.sv
